// ----- hw/rtl/grsd_pkg.sv -----
// Shared types and constants of the Golomb-Rice set decoder.
package grsd_pkg;

   localparam int RiceW   = 6;
   localparam int RemW    = 32;
   localparam int ValueW  = 64;
   localparam int CountW  = 32;
   localparam int CsrIdxW = 4;
   localparam int CsrDatW = 32;

   localparam logic [RiceW-1:0]   RiceMax   = 6'd32;
   localparam logic [RiceW-1:0]   RiceReset = 6'd19;

   localparam logic [CsrIdxW-1:0] CsrRiceBits     = 4'd0;
   localparam logic [CsrIdxW-1:0] CsrElementCount = 4'd1;

   typedef struct packed {
      logic [7:0] stream_byte;
      logic       start_req;
   } grsd_req_type;

   typedef struct packed {
      logic [ValueW-1:0] set_value;
      logic [CountW-1:0] element_index;
      logic              last;
   } grsd_rsp_type;

   typedef struct packed {
      logic [CsrIdxW-1:0] index;
      logic [CsrDatW-1:0] data;
   } grsd_csr_type;

   // Decoder state and the byte window handed to the bit scanner.
   typedef struct packed {
      logic [7:0]       stream_byte;
      logic [2:0]       pos;
      logic             in_rem;
      logic [RemW-1:0]  rem;
      logic [RiceW-1:0] seen;
      logic [RiceW-1:0] rice;
   } grsd_scan_in_type;

   typedef struct packed {
      logic             emit;
      logic             byte_done;
      logic [2:0]       next_pos;
      logic             in_rem;
      logic [3:0]       ones;
      logic [RemW-1:0]  rem;
      logic [RiceW-1:0] seen;
   } grsd_scan_out_type;

   // One completed code on its way to the value adder.
   typedef struct packed {
      logic [ValueW-1:0] quotient;
      logic [RemW-1:0]   rem;
      logic [RiceW-1:0]  shift;
      logic [CountW-1:0] index;
      logic              last;
      logic              restart;
   } grsd_code_type;

endpackage

// ----- hw/rtl/grsd_chan_if.sv -----
// Valid/ready channel carrying one payload per beat.
interface grsd_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/golomb_rice_set_decoder.sv -----
// Golomb-Rice coded set decoder: stream bytes in, rebuilt set values out.
//
//   Channel   Role  Beat contents
//   req_bus   in    stream_byte, start_req
//   rsp_bus   out   set_value, element_index, last
//   csr_bus   in    index (0 rice_bits, 1 element_count), data
//
// The scanner stops at each code that a byte completes and takes up the rest of the byte in
// a further step, unless that code ends on the final bit of the byte; a byte that completes
// no code is scanned whole at once. A scanner step waits while the code register is held.
// A result passes from the scanner through the code register into the output register.
// Reset clears all decoder state, rice_bits to 19 and element_count to 0.
// A stalled rsp_bus holds the result register, then the code register, then the scanner.
module golomb_rice_set_decoder (
   input logic       clock,
   input logic       reset,
   grsd_chan_if.sink   req_bus,
   grsd_chan_if.source rsp_bus,
   grsd_chan_if.sink   csr_bus
);
   import grsd_pkg::*;

   // Configuration.
   logic [RiceW-1:0]  rice_ff;
   logic [CountW-1:0] ecount_ff;
   logic [RiceW-1:0]  rice_eff;

   // Input byte window.
   logic             busy_ff, busy_in;
   logic [7:0]       byte_ff, byte_in;
   logic [2:0]       pos_ff, pos_in;
   logic             start_ff, start_in;

   // Decoder state.
   logic              in_rem_ff, in_rem_in;
   logic [ValueW-1:0] quot_ff, quot_in;
   logic [RemW-1:0]   rem_ff, rem_in;
   logic [RiceW-1:0]  seen_ff, seen_in;
   logic [CountW-1:0] dec_ff, dec_in;
   logic              fin_ff, fin_in;
   logic              pend_ff, pend_in;

   // Code and result stages.
   logic              code_valid_ff, code_valid_in;
   grsd_code_type     code_ff, code_in;
   logic              rsp_valid_ff, rsp_valid_in;
   grsd_rsp_type      rsp_ff, rsp_in;
   logic [ValueW-1:0] prev_ff, prev_in;

   // Base state for this step: a start byte sees the cleared state.
   logic              b_in_rem;
   logic [ValueW-1:0] b_quot;
   logic [RemW-1:0]   b_rem;
   logic [RiceW-1:0]  b_seen;
   logic [CountW-1:0] b_dec;
   logic              b_fin;
   logic              b_pend;
   logic              fin0;
   logic [CountW:0]   dec_inc;
   logic [ValueW-1:0] quot_sum;

   logic rsp_free, code_adv, code_free, a_fire, a_done, req_fire;
   logic [ValueW-1:0] value;

   grsd_scan_in_type  scan_in;
   grsd_scan_out_type scan_out;

   assign rice_eff = (rice_ff > RiceMax) ? RiceMax : rice_ff;

   always_comb begin
      if (start_ff) begin
         b_in_rem = 1'b0;
         b_quot   = '0;
         b_rem    = '0;
         b_seen   = '0;
         b_dec    = '0;
         b_fin    = 1'b0;
         b_pend   = 1'b1;
      end else begin
         b_in_rem = in_rem_ff;
         b_quot   = quot_ff;
         b_rem    = rem_ff;
         b_seen   = seen_ff;
         b_dec    = dec_ff;
         b_fin    = fin_ff;
         b_pend   = pend_ff;
      end
   end

   assign scan_in.stream_byte = byte_ff;
   assign scan_in.pos         = pos_ff;
   assign scan_in.in_rem      = b_in_rem;
   assign scan_in.rem         = b_rem;
   assign scan_in.seen        = b_seen;
   assign scan_in.rice        = rice_eff;

   grsd_scan u_scan (
      .scan_in  (scan_in),
      .scan_out (scan_out)
   );

   assign fin0     = b_fin || (b_dec >= ecount_ff);
   assign dec_inc  = {1'b0, b_dec} + 33'd1;
   assign quot_sum = b_quot + 64'(scan_out.ones);

   assign rsp_free  = !rsp_valid_ff || rsp_bus.ready;
   assign code_adv  = code_valid_ff && rsp_free;
   assign code_free = !code_valid_ff || code_adv;
   assign a_fire    = busy_ff && code_free;
   assign a_done    = fin0 || scan_out.byte_done;

   assign req_bus.ready = !busy_ff || (a_fire && a_done);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.payload = rsp_ff;

   // Scanner step and byte window.
   always_comb begin
      busy_in       = busy_ff;
      byte_in       = byte_ff;
      pos_in        = pos_ff;
      start_in      = start_ff;
      in_rem_in     = in_rem_ff;
      quot_in       = quot_ff;
      rem_in        = rem_ff;
      seen_in       = seen_ff;
      dec_in        = dec_ff;
      fin_in        = fin_ff;
      pend_in       = pend_ff;
      code_valid_in = code_valid_ff && !code_adv;
      code_in       = code_ff;

      if (a_fire) begin
         busy_in  = !a_done;
         pos_in   = scan_out.next_pos;
         start_in = 1'b0;
         pend_in  = b_pend;
         dec_in   = b_dec;
         if (fin0) begin
            in_rem_in = b_in_rem;
            quot_in   = b_quot;
            rem_in    = b_rem;
            seen_in   = b_seen;
            fin_in    = 1'b1;
         end else if (scan_out.emit) begin
            code_valid_in   = 1'b1;
            code_in.quotient = quot_sum;
            code_in.rem      = scan_out.rem;
            code_in.shift    = rice_eff;
            code_in.index    = b_dec;
            code_in.last     = (dec_inc == {1'b0, ecount_ff});
            code_in.restart  = b_pend;
            pend_in   = 1'b0;
            in_rem_in = 1'b0;
            quot_in   = '0;
            rem_in    = '0;
            seen_in   = '0;
            dec_in    = dec_inc[CountW-1:0];
            fin_in    = (dec_inc >= {1'b0, ecount_ff});
         end else begin
            in_rem_in = scan_out.in_rem;
            quot_in   = quot_sum;
            rem_in    = scan_out.rem;
            seen_in   = scan_out.seen;
            fin_in    = b_fin;
         end
      end

      if (req_fire) begin
         busy_in  = 1'b1;
         byte_in  = req_bus.payload.stream_byte;
         pos_in   = '0;
         start_in = req_bus.payload.start_req;
      end
   end

   // Value adder: the previous value restarts from zero after a start byte.
   assign value = (code_ff.restart ? '0 : prev_ff) + (code_ff.quotient << code_ff.shift)
                  + 64'(code_ff.rem);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_in       = rsp_ff;
      prev_in      = prev_ff;
      if (code_adv) begin
         rsp_valid_in         = 1'b1;
         rsp_in.set_value     = value;
         rsp_in.element_index = code_ff.index;
         rsp_in.last          = code_ff.last;
         prev_in              = value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rice_ff       <= RiceReset;
         ecount_ff     <= '0;
         busy_ff       <= 1'b0;
         start_ff      <= 1'b0;
         pos_ff        <= '0;
         in_rem_ff     <= 1'b0;
         quot_ff       <= '0;
         rem_ff        <= '0;
         seen_ff       <= '0;
         dec_ff        <= '0;
         fin_ff        <= 1'b0;
         pend_ff       <= 1'b0;
         code_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         prev_ff       <= '0;
      end else begin
         if (csr_bus.valid) begin
            unique case (csr_bus.payload.index)
               CsrRiceBits:     rice_ff   <= csr_bus.payload.data[RiceW-1:0];
               CsrElementCount: ecount_ff <= csr_bus.payload.data[CountW-1:0];
               default: ;
            endcase
         end
         busy_ff       <= busy_in;
         start_ff      <= start_in;
         pos_ff        <= pos_in;
         in_rem_ff     <= in_rem_in;
         quot_ff       <= quot_in;
         rem_ff        <= rem_in;
         seen_ff       <= seen_in;
         dec_ff        <= dec_in;
         fin_ff        <= fin_in;
         pend_ff       <= pend_in;
         code_valid_ff <= code_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         prev_ff       <= prev_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      code_ff <= code_in;
      rsp_ff  <= rsp_in;
   end

endmodule

// ----- hw/rtl/grsd_scan.sv -----
// Bit scanner: walks the unconsumed bits of one byte up to the next completed code.
module grsd_scan (
   input  grsd_pkg::grsd_scan_in_type  scan_in,
   output grsd_pkg::grsd_scan_out_type scan_out
);
   import grsd_pkg::*;

   logic             in_rem;
   logic [3:0]       ones;
   logic [RemW-1:0]  rem;
   logic [RiceW-1:0] seen;
   logic             stop;
   logic [3:0]       npos;
   logic             bit_v;

   always_comb begin
      in_rem = scan_in.in_rem;
      ones   = '0;
      rem    = scan_in.rem;
      seen   = scan_in.seen;
      stop   = 1'b0;
      npos   = 4'd8;
      bit_v  = 1'b0;
      for (int j = 0; j < 8; j++) begin
         if (!stop && (4'(j) >= {1'b0, scan_in.pos})) begin
            bit_v = scan_in.stream_byte[3'(7 - j)];
            if (!in_rem) begin
               if (bit_v) begin
                  ones = ones + 4'd1;
               end else begin
                  in_rem = 1'b1;
                  rem    = '0;
                  seen   = '0;
                  // With no remainder bits the ending zero completes the code.
                  if (scan_in.rice == '0) begin
                     stop = 1'b1;
                     npos = 4'(j + 1);
                  end
               end
            end else begin
               rem = {rem[RemW-2:0], bit_v};
               if (seen < RiceMax) begin
                  seen = seen + 6'd1;
               end
               if (seen >= scan_in.rice) begin
                  stop = 1'b1;
                  npos = 4'(j + 1);
               end
            end
         end
      end
      scan_out.emit      = stop;
      scan_out.byte_done = npos[3];
      scan_out.next_pos  = npos[2:0];
      scan_out.in_rem    = in_rem;
      scan_out.ones      = ones;
      scan_out.rem       = rem;
      scan_out.seen      = seen;
   end

endmodule
